>>> rtl/metb_pkg.sv
`timescale 1ns / 1ps

package metb_pkg;

	localparam int MAX_EDGES_DEF = 256;

	typedef enum logic [1:0] {
		FN_CLEAR  = 2'd0,
		FN_VERTEX = 2'd1,
		FN_READ   = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_NEW     = 3'd0,
		ST_MERGED  = 3'd1,
		ST_DROPPED = 3'd2,
		ST_READ    = 3'd3,
		ST_CLEARED = 3'd4,
		ST_RANGE   = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] va;
		logic [7:0] vb;
		logic [7:0] fa;
		logic [7:0] fb;
		logic       fb_ok;
	} entry_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic scan;
		logic emit;
	} metb_cmd_t;

	typedef struct packed {
		logic dec_edge;
		logic dec_emit;
		logic scan_done;
		logic out_free;
		logic second_pend;
	} metb_sts_t;

endpackage

>>> rtl/metb_datapath.sv
`timescale 1ns / 1ps

module metb_datapath #(
	parameter int MAX_EDGES = metb_pkg::MAX_EDGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  metb_pkg::metb_cmd_t cmd,
	output metb_pkg::metb_sts_t sts,
	input  logic [1:0]          func,
	input  logic [7:0]          vertex_index,
	input  logic [7:0]          face_id,
	input  logic                last_in_face,
	input  logic [7:0]          read_index,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [2:0]          status,
	output logic [7:0]          edge_index,
	output logic [7:0]          end_vertex_a,
	output logic [7:0]          end_vertex_b,
	output logic [7:0]          first_face,
	output logic [7:0]          second_face,
	output logic                second_face_valid,
	output logic [8:0]          edge_total,
	output logic                last_result
);
	import metb_pkg::*;

	localparam int AW = $clog2(MAX_EDGES);
	localparam int FW = $clog2(MAX_EDGES + 1);
	localparam int XW = (FW > 9) ? FW : 9;

	entry_t mem [MAX_EDGES];
	entry_t rdata_q;

	func_t          func_q;
	logic [7:0]     vtx_q;
	logic [7:0]     face_q;
	logic           last_q;
	logic [7:0]     ridx_q;

	logic [FW-1:0]  fill_q;
	logic           inside_q;
	logic           sec_q;
	logic [7:0]     first_q;
	logic [7:0]     prior_q;
	logic [FW-1:0]  scan_q;
	logic           pend_s1;
	logic [AW-1:0]  pidx_s1;
	logic           out_valid_q;

	logic [7:0]     ea_q;
	logic [7:0]     eb_q;
	logic           elast_q;
	status_t        kind_q;
	logic [AW-1:0]  idx_q;

	logic [2:0]     status_q;
	logic [7:0]     edge_index_q;
	entry_t         res_q;
	logic [8:0]     edge_total_q;
	logic           last_result_q;

	logic           hit;
	logic           more;
	logic           full;
	logic           out_free;
	logic           do_emit;
	logic [XW-1:0]  ridx_x;
	logic [XW-1:0]  fill_x;
	logic [XW-1:0]  idx_x;
	logic [FW-1:0]  fill_inc;
	logic [XW-1:0]  fill_inc_x;
	logic           ridx_ok;

	logic           re;
	logic [AW-1:0]  raddr;
	logic           we;
	entry_t         wdata;
	entry_t         new_entry;
	entry_t         merged_entry;
	entry_t         res_entry;
	logic [7:0]     res_index;
	logic [8:0]     res_total;

	logic           start;
	logic [7:0]     st_a;
	logic [7:0]     st_b;
	logic           st_last;

	assign hit = pend_s1 && ((rdata_q.va == ea_q && rdata_q.vb == eb_q) ||
		(rdata_q.va == eb_q && rdata_q.vb == ea_q));
	assign more       = scan_q < fill_q;
	assign full       = fill_q == FW'(MAX_EDGES);
	assign out_free   = !out_valid_q || !out_stall;
	assign do_emit    = cmd.emit && out_free;
	assign ridx_x     = XW'(ridx_q);
	assign fill_x     = XW'(fill_q);
	assign idx_x      = XW'(idx_q);
	assign fill_inc   = fill_q + FW'(1);
	assign fill_inc_x = XW'(fill_inc);
	assign ridx_ok    = ridx_x < fill_x;

	assign sts.dec_edge    = (func_q == FN_VERTEX) && (inside_q || last_q);
	assign sts.dec_emit    = (func_q == FN_CLEAR) || (func_q == FN_READ);
	assign sts.scan_done   = hit || !more;
	assign sts.out_free    = out_free;
	assign sts.second_pend = sec_q;

	assign new_entry    = '{va: ea_q, vb: eb_q, fa: face_q, fb: 8'd0, fb_ok: 1'b0};
	assign merged_entry = '{va: rdata_q.va, vb: rdata_q.vb, fa: rdata_q.fa,
		fb: face_q, fb_ok: 1'b1};

	assign re    = (cmd.scan && !hit && more) || (cmd.decode && func_q == FN_READ);
	assign raddr = cmd.decode ? ridx_x[AW-1:0] : scan_q[AW-1:0];
	assign we    = do_emit && (kind_q == ST_NEW || kind_q == ST_MERGED);
	assign wdata = (kind_q == ST_NEW) ? new_entry : merged_entry;

	always_comb begin
		res_entry = '0;
		res_index = 8'd0;
		res_total = fill_x[8:0];
		case (kind_q)
			ST_NEW: begin
				res_entry = new_entry;
				res_index = idx_x[7:0];
				res_total = fill_inc_x[8:0];
			end
			ST_MERGED: begin
				res_entry = merged_entry;
				res_index = idx_x[7:0];
			end
			ST_DROPPED: begin
				res_entry = new_entry;
			end
			ST_READ: begin
				res_entry = rdata_q;
				res_index = ridx_q;
			end
			ST_RANGE: begin
				res_index = ridx_q;
			end
			default: begin
				res_entry = '0;
			end
		endcase
	end

	// edge setup: open-face or one-vertex-face edge on decode, closing edge after the first result
	always_comb begin
		start   = 1'b0;
		st_a    = prior_q;
		st_b    = vtx_q;
		st_last = !last_q;
		if (cmd.decode && func_q == FN_VERTEX) begin
			if (inside_q) begin
				start = 1'b1;
			end else if (last_q) begin
				start   = 1'b1;
				st_a    = vtx_q;
				st_last = 1'b1;
			end
		end
		if (do_emit && sec_q) begin
			start   = 1'b1;
			st_a    = vtx_q;
			st_b    = first_q;
			st_last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx_q] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			inside_q    <= 1'b0;
			sec_q       <= 1'b0;
			first_q     <= 8'd0;
			prior_q     <= 8'd0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.decode) begin
				case (func_q)
					FN_CLEAR: begin
						fill_q   <= '0;
						inside_q <= 1'b0;
						sec_q    <= 1'b0;
					end
					FN_VERTEX: begin
						prior_q <= vtx_q;
						if (!inside_q) begin
							first_q  <= vtx_q;
							inside_q <= !last_q;
						end else begin
							sec_q <= last_q;
						end
					end
					default: begin
						sec_q <= sec_q;
					end
				endcase
			end
			if (start) begin
				scan_q  <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.scan) begin
				if (hit || !more) begin
					pend_s1 <= 1'b0;
				end else begin
					pend_s1 <= 1'b1;
					scan_q  <= scan_q + FW'(1);
				end
			end
			if (do_emit) begin
				if (kind_q == ST_NEW) begin
					fill_q <= fill_inc;
				end
				if (sec_q) begin
					sec_q    <= 1'b0;
					inside_q <= 1'b0;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(func);
			vtx_q  <= vertex_index;
			face_q <= face_id;
			last_q <= last_in_face;
			ridx_q <= read_index;
		end
		if (start) begin
			ea_q    <= st_a;
			eb_q    <= st_b;
			elast_q <= st_last;
		end
		if (cmd.decode && func_q == FN_CLEAR) begin
			kind_q  <= ST_CLEARED;
			elast_q <= 1'b1;
		end
		if (cmd.decode && func_q == FN_READ) begin
			kind_q  <= ridx_ok ? ST_READ : ST_RANGE;
			elast_q <= 1'b1;
		end
		if (cmd.scan) begin
			if (!hit && more) begin
				pidx_s1 <= scan_q[AW-1:0];
			end
			if (hit || !more) begin
				kind_q <= hit ? ST_MERGED : (full ? ST_DROPPED : ST_NEW);
				idx_q  <= hit ? pidx_s1 : fill_q[AW-1:0];
			end
		end
		if (do_emit) begin
			status_q      <= kind_q;
			edge_index_q  <= res_index;
			res_q         <= res_entry;
			edge_total_q  <= res_total;
			last_result_q <= elast_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign edge_index        = edge_index_q;
	assign end_vertex_a      = res_q.va;
	assign end_vertex_b      = res_q.vb;
	assign first_face        = res_q.fa;
	assign second_face       = res_q.fb;
	assign second_face_valid = res_q.fb_ok;
	assign edge_total        = edge_total_q;
	assign last_result       = last_result_q;

endmodule

>>> rtl/metb_ctrl.sv
`timescale 1ns / 1ps

module metb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output metb_pkg::metb_cmd_t cmd,
	input  metb_pkg::metb_sts_t sts
);
	import metb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_SCAN   = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.dec_edge) begin
					state_d = S_SCAN;
				end else if (sts.dec_emit) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.second_pend ? S_SCAN : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall   = state_q != S_IDLE;
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.decode = state_q == S_DECODE;
	assign cmd.scan   = state_q == S_SCAN;
	assign cmd.emit   = state_q == S_EMIT;

endmodule

>>> rtl/mesh_edge_table_builder_unit.sv
`timescale 1ns / 1ps

// Builds an edge adjacency table from a stream of face vertices. One item is
// taken at a time. A clear or a read is decoded and then emitted; an ignored
// code or the opening vertex of a face is only decoded.
// Each edge is found by a linear search of the table through a single-port
// memory, one stored entry per cycle, so the search time grows with N, the
// number of stored edges (at most MAX_EDGES). A result waiting on a stalled
// output holds off the following result, and with it the taking of new items.
module mesh_edge_table_builder_unit #(
	parameter int MAX_EDGES = metb_pkg::MAX_EDGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [7:0] vertex_index,
	input  logic [7:0] face_id,
	input  logic       last_in_face,
	input  logic [7:0] read_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] edge_index,
	output logic [7:0] end_vertex_a,
	output logic [7:0] end_vertex_b,
	output logic [7:0] first_face,
	output logic [7:0] second_face,
	output logic       second_face_valid,
	output logic [8:0] edge_total,
	output logic       last_result
);
	import metb_pkg::*;

	metb_cmd_t cmd;
	metb_sts_t sts;

	metb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	metb_datapath #(
		.MAX_EDGES (MAX_EDGES)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.func              (func),
		.vertex_index      (vertex_index),
		.face_id           (face_id),
		.last_in_face      (last_in_face),
		.read_index        (read_index),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.status            (status),
		.edge_index        (edge_index),
		.end_vertex_a      (end_vertex_a),
		.end_vertex_b      (end_vertex_b),
		.first_face        (first_face),
		.second_face       (second_face),
		.second_face_valid (second_face_valid),
		.edge_total        (edge_total),
		.last_result       (last_result)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input transfer did not start processing");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CLEARED |-> edge_total == 9'd0 && last_result)
		else $error("clear result with nonzero total or not final");

	a_closing_edge: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.out_free && sts.second_pend |=> cmd.scan)
		else $error("closing edge of face not searched");

	a_merged_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_MERGED |-> second_face_valid)
		else $error("merged edge without second face");

endmodule

>>> bench/mesh_edge_table_builder_unit_test.sv
`timescale 1ns / 1ps

module mesh_edge_table_builder_unit_test;
	import metb_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [7:0] edge_index;
		entry_t     entry;
		logic [8:0] edge_total;
		logic       last_result;
	} edge_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] func = FN_CLEAR;
	logic [7:0] vertex_index = 8'd0;
	logic [7:0] face_id = 8'd0;
	logic       last_in_face = 1'b0;
	logic [7:0] read_index = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] status;
	logic [7:0] edge_index;
	logic [7:0] end_vertex_a;
	logic [7:0] end_vertex_b;
	logic [7:0] first_face;
	logic [7:0] second_face;
	logic       second_face_valid;
	logic [8:0] edge_total;
	logic       last_result;

	entry_t       edge_table [256];
	int           table_fill = 0;
	logic [7:0]   loop_start_vertex = 8'd0;
	logic [7:0]   prior_vertex = 8'd0;
	logic         face_open = 1'b0;
	edge_result_t pending_edge_results [$];

	int errors = 0;
	int burst_left = 0;
	int stall_hold = 0;
	int stall_mode = 0;

	mesh_edge_table_builder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.vertex_index(vertex_index),
		.face_id(face_id),
		.last_in_face(last_in_face),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.edge_index(edge_index),
		.end_vertex_a(end_vertex_a),
		.end_vertex_b(end_vertex_b),
		.first_face(first_face),
		.second_face(second_face),
		.second_face_valid(second_face_valid),
		.edge_total(edge_total),
		.last_result(last_result)
	);

	always #1 clk = ~clk;

	function automatic void queue_result(status_t s, logic [7:0] idx, entry_t e, logic lst);
		edge_result_t r;
		r.status = s;
		r.edge_index = idx;
		r.entry = e;
		r.edge_total = 9'(table_fill);
		r.last_result = lst;
		pending_edge_results.push_back(r);
	endfunction

	// unordered pair lookup; a hit overwrites the second face
	function automatic void record_edge(logic [7:0] a, logic [7:0] b, logic [7:0] face,
		logic lst);
		int i;
		entry_t e;
		for (i = 0; i < table_fill; i++) begin
			if ((edge_table[i].va == a && edge_table[i].vb == b) ||
			    (edge_table[i].va == b && edge_table[i].vb == a)) begin
				edge_table[i].fb = face;
				edge_table[i].fb_ok = 1'b1;
				queue_result(ST_MERGED, 8'(i), edge_table[i], lst);
				return;
			end
		end
		e.va = a;
		e.vb = b;
		e.fa = face;
		e.fb = 8'd0;
		e.fb_ok = 1'b0;
		if (table_fill >= 256) begin
			queue_result(ST_DROPPED, 8'd0, e, lst);
			return;
		end
		edge_table[table_fill] = e;
		table_fill++;
		queue_result(ST_NEW, 8'(table_fill - 1), e, lst);
	endfunction

	function automatic void apply_item(func_t f, logic [7:0] v, logic [7:0] fc, logic lst,
		logic [7:0] ridx);
		case (f)
			FN_CLEAR: begin
				table_fill = 0;
				face_open = 1'b0;
				queue_result(ST_CLEARED, 8'd0, '0, 1'b1);
			end
			FN_READ: begin
				if (ridx < table_fill)
					queue_result(ST_READ, ridx, edge_table[ridx], 1'b1);
				else
					queue_result(ST_RANGE, ridx, '0, 1'b1);
			end
			FN_VERTEX: begin
				if (!face_open) begin
					loop_start_vertex = v;
					prior_vertex = v;
					if (lst)
						record_edge(v, v, fc, 1'b1);
					else
						face_open = 1'b1;
				end else begin
					record_edge(prior_vertex, v, fc, !lst);
					prior_vertex = v;
					if (lst) begin
						record_edge(v, loop_start_vertex, fc, 1'b1);
						face_open = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		edge_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_edge_results.size() == 0) begin
				$display("%0t: unexpected transfer, status expected none actual %0d",
					$time, status);
				errors++;
			end else begin
				want = pending_edge_results.pop_front();
				check_field("status", want.status, status);
				check_field("edge_index", want.edge_index, edge_index);
				check_field("end_vertex_a", want.entry.va, end_vertex_a);
				check_field("end_vertex_b", want.entry.vb, end_vertex_b);
				check_field("first_face", want.entry.fa, first_face);
				check_field("second_face", want.entry.fb, second_face);
				check_field("second_face_valid", want.entry.fb_ok, second_face_valid);
				check_field("edge_total", want.edge_total, edge_total);
				check_field("last_result", want.last_result, last_result);
			end
		end
	end

	// receiver: free-running, with no-stall, light and heavy stall phases
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_hold <= $urandom_range(16, 160);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic send_item(func_t f, logic [7:0] v, logic [7:0] fc, logic lst,
		logic [7:0] ridx);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= f;
		vertex_index <= v;
		face_id <= fc;
		last_in_face <= lst;
		read_index <= ridx;
		do @(posedge clk); while (in_stall);
		apply_item(f, v, fc, lst, ridx);
	endtask

	task automatic hold_until_drained;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_edge_results.size() != 0);
	endtask

	task automatic test_clear_and_empty_reads;
		send_item(FN_CLEAR, 8'hff, 8'hff, 1'b1, 8'hff);
		send_item(FN_READ, 8'h00, 8'h00, 1'b0, 8'd0);
		send_item(FN_READ, 8'hff, 8'hff, 1'b1, 8'd255);
	endtask

	task automatic test_face_shapes;
		// single vertex face closes on itself; face number changes mid face
		send_item(FN_VERTEX, 8'd0, 8'd0, 1'b1, 8'h00);
		send_item(FN_VERTEX, 8'd255, 8'd255, 1'b0, 8'hff);
		send_item(FN_VERTEX, 8'd0, 8'd255, 1'b0, 8'h00);
		send_item(FN_VERTEX, 8'd128, 8'd7, 1'b1, 8'hff);
	endtask

	task automatic test_shared_edges;
		send_item(FN_VERTEX, 8'd0, 8'd1, 1'b0, 8'h00);
		send_item(FN_VERTEX, 8'd255, 8'd2, 1'b1, 8'h00);
		send_item(FN_VERTEX, 8'd255, 8'd9, 1'b0, 8'h00);
		send_item(FN_VERTEX, 8'd0, 8'd9, 1'b1, 8'h00);
		send_item(FN_READ, 8'd0, 8'd0, 1'b0, 8'd1);
	endtask

	task automatic test_ignored_code_and_abandon;
		send_item(FN_NONE, 8'hff, 8'hff, 1'b1, 8'hff);
		send_item(FN_VERTEX, 8'd5, 8'd4, 1'b0, 8'h00);
		send_item(FN_NONE, 8'h00, 8'h00, 1'b1, 8'h00);
		send_item(FN_VERTEX, 8'd6, 8'd4, 1'b0, 8'h00);
		send_item(FN_CLEAR, 8'd0, 8'd0, 1'b0, 8'd0);
		send_item(FN_VERTEX, 8'd9, 8'd1, 1'b1, 8'h00);
		send_item(FN_READ, 8'd0, 8'd0, 1'b0, 8'd0);
		send_item(FN_READ, 8'd0, 8'd0, 1'b0, 8'd1);
	endtask

	task automatic test_table_overflow;
		int k;
		send_item(FN_CLEAR, 8'd0, 8'd0, 1'b0, 8'd0);
		for (k = 0; k < 256; k++)
			send_item(FN_VERTEX, 8'(k), 8'd10, k == 255, 8'(k));
		send_item(FN_VERTEX, 8'd1, 8'd20, 1'b0, 8'd0);
		send_item(FN_VERTEX, 8'd2, 8'd20, 1'b0, 8'd0);
		send_item(FN_VERTEX, 8'd100, 8'd20, 1'b1, 8'd0);
		send_item(FN_VERTEX, 8'd7, 8'd21, 1'b1, 8'd0);
		send_item(FN_READ, 8'd0, 8'd0, 1'b0, 8'd255);
		send_item(FN_READ, 8'd0, 8'd0, 1'b0, 8'd1);
		hold_until_drained;
		send_item(FN_CLEAR, 8'd0, 8'd0, 1'b0, 8'd0);
	endtask

	task automatic test_random_traffic;
		int done_items;
		int pick;
		int len;
		int k;
		logic       narrow;
		logic [7:0] face;
		logic [7:0] v;
		done_items = 0;
		while (done_items < 420) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
				narrow = ($urandom_range(0, 4) != 0);
				face = 8'($urandom_range(0, 255));
				for (k = 0; k < len; k++) begin
					// broken faces: stray read or clear in mid face
					if ($urandom_range(0, 24) == 0) begin
						if ($urandom_range(0, 1) == 0)
							send_item(FN_READ, 8'($urandom_range(0, 255)),
								8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
								8'($urandom_range(0, 255)));
						else
							send_item(FN_CLEAR, 8'($urandom_range(0, 255)),
								8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
								8'($urandom_range(0, 255)));
						done_items++;
					end
					v = narrow ? 8'($urandom_range(0, 11)) : 8'($urandom_range(0, 255));
					if ($urandom_range(0, 9) == 0)
						face = 8'($urandom_range(0, 255));
					send_item(FN_VERTEX, v, face, k == len - 1, 8'($urandom_range(0, 255)));
				end
				done_items += len;
			end else if (pick < 84) begin
				if (table_fill > 0 && $urandom_range(0, 3) != 0)
					v = 8'($urandom_range(0, table_fill - 1));
				else
					v = 8'($urandom_range(0, 255));
				send_item(FN_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), v);
				done_items++;
			end else if (pick < 92) begin
				send_item(FN_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end else if (pick < 94) begin
				send_item(FN_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				done_items++;
			end else begin
				send_item(FN_VERTEX, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				done_items++;
			end
			if ($urandom_range(0, 99) == 0)
				hold_until_drained;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clear_and_empty_reads;
		test_face_shapes;
		test_shared_edges;
		test_ignored_code_and_abandon;
		test_table_overflow;
		test_random_traffic;
		hold_until_drained;
		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
